// File: rtl/core/rgh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgh_pkg: shared types and constants for the horizontal grid ray caster
// Item layouts, fixed-point geometry of the world and the probe record that
// passes from the probe logic to the control loop.
// ----------------------------------------------------------------------------
package rgh_pkg;

  // Map and fixed-point geometry.
  localparam int TILE_SHIFT   = 6;
  localparam int MAP_COLS     = 16;
  localparam int MAP_ROWS     = 16;
  localparam int CELL_BITS    = 8;
  localparam int FRAC_BITS    = 8;
  localparam int TILE_Q_SHIFT = TILE_SHIFT + FRAC_BITS;
  localparam int MAP_DEPTH    = MAP_COLS * MAP_ROWS;
  localparam int ADDR_W       = $clog2(MAP_DEPTH);
  localparam int COL_W        = $clog2(MAP_COLS);
  localparam int ROW_W        = $clog2(MAP_ROWS);

  // Field widths of the items.
  localparam int IN_POS_W  = 18;
  localparam int COT_W     = 24;
  localparam int OUT_POS_W = 19;
  localparam int WALL_W    = 8;

  // Internal signed position width: holds a start x far outside the world
  // plus one further step.
  localparam int POS_W  = 34;
  // Distance from the player to the first grid line, signed.
  localparam int DY_W   = TILE_Q_SHIFT + 2;
  localparam int PROD_W = DY_W + COT_W;

  localparam logic signed [POS_W-1:0] TILE    = POS_W'(2 ** TILE_Q_SHIFT);
  localparam logic signed [POS_W-1:0] UNIT    = POS_W'(2 ** FRAC_BITS);
  localparam logic signed [POS_W-1:0] WORLD_W = POS_W'(MAP_COLS * (2 ** TILE_Q_SHIFT));
  localparam logic signed [POS_W-1:0] WORLD_H = POS_W'(MAP_ROWS * (2 ** TILE_Q_SHIFT));
  localparam logic signed [POS_W-1:0] COLS_S  = POS_W'(MAP_COLS);
  localparam logic signed [POS_W-1:0] ROWS_S  = POS_W'(MAP_ROWS);

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  // Wall value reported when the ray leaves the map.
  localparam logic [WALL_W-1:0] WALL_BOUNDARY = WALL_W'(1);

  typedef struct packed {
    logic                       kind;
    logic [3:0]                 cell_col;
    logic [3:0]                 cell_row;
    logic [7:0]                 cell_value;
    logic [IN_POS_W-1:0]        player_x;
    logic [IN_POS_W-1:0]        player_y;
    logic signed [COT_W-1:0]    ray_cotangent;
    logic                       facing_up;
    logic                       facing_left;
  } in_item_t;

  typedef struct packed {
    logic                 hit_found;
    logic [OUT_POS_W-1:0] hit_x;
    logic [OUT_POS_W-1:0] hit_y;
    logic [WALL_W-1:0]    wall_value;
  } out_item_t;

  // Result of probing one crossing point.
  typedef struct packed {
    logic              in_range;
    logic              boundary;
    logic [ADDR_W-1:0] addr;
  } probe_t;

endpackage

// File: rtl/core/ray_grid_horizontal_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_grid_horizontal_intersect: first wall crossing on horizontal grid lines
// Tile map in a synchronous RAM, written one cell per item, and a ray caster
// that walks the horizontal grid lines and reads the cell beside each one.
// ----------------------------------------------------------------------------
// After reset the block clears the 256-cell map, one cell a cycle, and takes
// no item until the sweep is done. A write item returns nothing. A cast item
// visits n horizontal grid crossings (at most MAP_ROWS): the set-up states
// SETUP, MUL and LOAD compute the first crossing (MUL does the dy by cotangent
// multiply), then the stepping loop issues one map RAM read per crossing per
// cycle and judges each crossing in the cycle after, when its read data
// returns. One item is worked on at a time; the next item is taken as soon as
// the previous result has been handed to the output register.
module ray_grid_horizontal_intersect (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rgh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rgh_pkg::out_item_t out_data
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SETUP = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_LOAD  = 7'b0010000,
    ST_RUN   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [rgh_pkg::ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [rgh_pkg::IN_POS_W-1:0]     px_r, px_nxt;
  logic [rgh_pkg::IN_POS_W-1:0]     py_r, py_nxt;
  logic signed [rgh_pkg::COT_W-1:0] cot_r, cot_nxt;
  logic                             up_r, up_nxt;
  logic                             left_r, left_nxt;

  logic signed [rgh_pkg::DY_W-1:0]   dy_r, dy_nxt;
  logic signed [rgh_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [rgh_pkg::POS_W-1:0]  x_r, x_nxt;
  logic signed [rgh_pkg::POS_W-1:0]  y_r, y_nxt;
  logic signed [rgh_pkg::POS_W-1:0]  xstep_r, xstep_nxt;

  logic                             pend_valid_r, pend_valid_nxt;
  logic                             pend_in_range_r, pend_in_range_nxt;
  logic                             pend_bound_r, pend_bound_nxt;
  logic [rgh_pkg::OUT_POS_W-1:0]    pend_x_r, pend_x_nxt;
  logic [rgh_pkg::OUT_POS_W-1:0]    pend_y_r, pend_y_nxt;

  rgh_pkg::out_item_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  rgh_pkg::out_item_t out_data_r, out_data_nxt;

  // Map RAM ports.
  logic                          ram_we;
  logic [rgh_pkg::ADDR_W-1:0]    ram_waddr;
  logic [rgh_pkg::CELL_BITS-1:0] ram_wdata;
  logic [rgh_pkg::CELL_BITS-1:0] ram_rdata;

  rgh_pkg::probe_t probe;

  // Set-up arithmetic.
  logic signed [rgh_pkg::POS_W-1:0]  px_ext;
  logic signed [rgh_pkg::POS_W-1:0]  py_ext;
  logic signed [rgh_pkg::POS_W-1:0]  y_floor;
  logic signed [rgh_pkg::POS_W-1:0]  y_first;
  logic signed [rgh_pkg::POS_W-1:0]  cot_step;
  logic signed [rgh_pkg::PROD_W-1:0] prod_sh;
  logic signed [rgh_pkg::POS_W-1:0]  ystep;

  // Decision on the probe whose read data is back.
  logic pend_hit;
  logic pend_finish;

  logic wr_in_map;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign px_ext   = rgh_pkg::POS_W'(px_r);
  assign py_ext   = rgh_pkg::POS_W'(py_r);
  assign y_floor  = (py_ext >>> rgh_pkg::TILE_Q_SHIFT) <<< rgh_pkg::TILE_Q_SHIFT;
  assign y_first  = up_r ? y_floor : (y_floor + rgh_pkg::TILE);
  assign cot_step = rgh_pkg::POS_W'(cot_r) <<< rgh_pkg::TILE_SHIFT;
  assign prod_sh  = prod_r >>> rgh_pkg::FRAC_BITS;
  assign ystep    = up_r ? -rgh_pkg::TILE : rgh_pkg::TILE;

  assign pend_hit    = pend_in_range_r && (pend_bound_r || (ram_rdata != '0));
  assign pend_finish = pend_valid_r && (!pend_in_range_r || pend_hit);

  assign wr_in_map = (int'(in_data.cell_col) < rgh_pkg::MAP_COLS) &&
                     (int'(in_data.cell_row) < rgh_pkg::MAP_ROWS);

  rgh_probe u_probe (
    .x     (x_r),
    .y     (y_r),
    .up    (up_r),
    .probe (probe)
  );

  rgh_ram #(
    .WIDTH (rgh_pkg::CELL_BITS),
    .DEPTH (rgh_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe.addr),
    .rdata (ram_rdata)
  );

  // Map write port: clearing sweep after reset, cell writes while idle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == ST_IDLE && in_valid &&
                 in_data.kind == rgh_pkg::KIND_WRITE && wr_in_map) begin
      ram_we    = 1'b1;
      ram_waddr = rgh_pkg::ADDR_W'(int'(in_data.cell_row) * rgh_pkg::MAP_COLS +
                                   int'(in_data.cell_col));
      ram_wdata = rgh_pkg::CELL_BITS'(in_data.cell_value);
    end
  end

  // Control sequence and stepping datapath.
  always_comb begin
    state_nxt         = state_r;
    clr_cnt_nxt       = clr_cnt_r;
    px_nxt            = px_r;
    py_nxt            = py_r;
    cot_nxt           = cot_r;
    up_nxt            = up_r;
    left_nxt          = left_r;
    dy_nxt            = dy_r;
    prod_nxt          = prod_r;
    x_nxt             = x_r;
    y_nxt             = y_r;
    xstep_nxt         = xstep_r;
    pend_valid_nxt    = 1'b0;
    pend_in_range_nxt = pend_in_range_r;
    pend_bound_nxt    = pend_bound_r;
    pend_x_nxt        = pend_x_r;
    pend_y_nxt        = pend_y_r;
    res_nxt           = res_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_data_nxt      = out_data_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == rgh_pkg::ADDR_W'(rgh_pkg::MAP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && in_data.kind == rgh_pkg::KIND_CAST) begin
          px_nxt    = in_data.player_x;
          py_nxt    = in_data.player_y;
          cot_nxt   = in_data.ray_cotangent;
          up_nxt    = in_data.facing_up;
          left_nxt  = in_data.facing_left;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        // First grid line and the signed distance to it; x step with the
        // sign set by the facing flag.
        y_nxt  = y_first;
        dy_nxt = rgh_pkg::DY_W'(y_first - py_ext);
        if (left_r && cot_step > 0) begin
          xstep_nxt = -cot_step;
        end else if (!left_r && cot_step < 0) begin
          xstep_nxt = -cot_step;
        end else begin
          xstep_nxt = cot_step;
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = rgh_pkg::PROD_W'(dy_r) * rgh_pkg::PROD_W'(cot_r);
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // The arithmetic shift rounds toward minus infinity.
        x_nxt     = px_ext + rgh_pkg::POS_W'(prod_sh);
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        // Issue a read for the current crossing and advance to the next one.
        pend_valid_nxt    = 1'b1;
        pend_in_range_nxt = probe.in_range;
        pend_bound_nxt    = probe.boundary;
        pend_x_nxt        = rgh_pkg::OUT_POS_W'(x_r);
        pend_y_nxt        = rgh_pkg::OUT_POS_W'(y_r);
        x_nxt             = x_r + xstep_r;
        y_nxt             = y_r + ystep;
        // Judge the crossing read in the previous cycle; later reads are dropped.
        if (pend_finish) begin
          pend_valid_nxt     = 1'b0;
          res_nxt.hit_found  = pend_hit;
          res_nxt.hit_x      = pend_hit ? pend_x_r : '0;
          res_nxt.hit_y      = pend_hit ? pend_y_r : '0;
          res_nxt.wall_value = !pend_hit ? '0 :
                               pend_bound_r ? rgh_pkg::WALL_BOUNDARY :
                               rgh_pkg::WALL_W'(ram_rdata);
          state_nxt          = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    px_r            <= px_nxt;
    py_r            <= py_nxt;
    cot_r           <= cot_nxt;
    up_r            <= up_nxt;
    left_r          <= left_nxt;
    dy_r            <= dy_nxt;
    prod_r          <= prod_nxt;
    x_r             <= x_nxt;
    y_r             <= y_nxt;
    xstep_r         <= xstep_nxt;
    pend_in_range_r <= pend_in_range_nxt;
    pend_bound_r    <= pend_bound_nxt;
    pend_x_r        <= pend_x_nxt;
    pend_y_r        <= pend_y_nxt;
    res_r           <= res_nxt;
    out_data_r      <= out_data_nxt;
  end

  // A crossing read is outstanding only inside the stepping loop.
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> state_r == ST_RUN)
    else $error("probe outstanding outside the stepping loop");

  // The map is written only by the clearing sweep or by an idle write item.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_IDLE))
    else $error("map write during a cast");

  // A miss reports all-zero fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit_found) |->
      (out_data.hit_x == '0 && out_data.hit_y == '0 && out_data.wall_value == '0))
    else $error("miss result carries nonzero fields");

  // A hit always names a nonempty cell.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit_found) |-> out_data.wall_value != '0)
    else $error("hit result with empty wall value");

  // A finished cast leaves the loop for the result stage in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && pend_finish) |=> state_r == ST_DONE)
    else $error("finished cast did not reach the result stage");

endmodule

// File: rtl/core/rgh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgh_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rgh_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/rgh_probe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgh_probe: crossing point check
// Decides whether a crossing lies in the world, whether the cell beside it
// lies outside the map, and forms the map address of that cell.
// ----------------------------------------------------------------------------
module rgh_probe (
  input  logic signed [rgh_pkg::POS_W-1:0] x,
  input  logic signed [rgh_pkg::POS_W-1:0] y,
  input  logic                             up,
  output rgh_pkg::probe_t                  probe
);

  logic signed [rgh_pkg::POS_W-1:0] cy;
  logic signed [rgh_pkg::POS_W-1:0] col_full;
  logic signed [rgh_pkg::POS_W-1:0] row_full;
  logic [rgh_pkg::COL_W-1:0]        col_idx;
  logic [rgh_pkg::ROW_W-1:0]        row_idx;

  // The checked cell lies just above the line when the ray goes up.
  assign cy       = up ? (y - rgh_pkg::UNIT) : y;
  assign col_full = x >>> rgh_pkg::TILE_Q_SHIFT;
  assign row_full = cy >>> rgh_pkg::TILE_Q_SHIFT;
  assign col_idx  = rgh_pkg::COL_W'(col_full);
  assign row_idx  = rgh_pkg::ROW_W'(row_full);

  // The loop keeps going only while the crossing is inside the world box.
  assign probe.in_range = (x >= 0) && (y >= 0) &&
                          (x <= rgh_pkg::WORLD_W) && (y <= rgh_pkg::WORLD_H);

  // A cell off the map reads as a wall.
  assign probe.boundary = (x < 0) || (cy < 0) ||
                          (col_full >= rgh_pkg::COLS_S) || (row_full >= rgh_pkg::ROWS_S);

  assign probe.addr = rgh_pkg::ADDR_W'(int'(row_idx) * rgh_pkg::MAP_COLS + int'(col_idx));

endmodule
